[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define JCS_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define JCS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

[src/jcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package jcs_pkg;

  localparam int PT_W       = 10;
  localparam int VAL_W      = 32;
  localparam int RES_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int NUM_NB   = 4;
  localparam int NUM_TAPS = 5;

  // Neighbor order inside the coefficient stages.
  localparam int NB_W = 0;
  localparam int NB_E = 1;
  localparam int NB_S = 2;
  localparam int NB_N = 3;

  // Tap order of weights and values: centre first, then the neighbors.
  localparam int TAP_C = 0;

  localparam int FACTOR_W   = 10;
  localparam int COEF_FRAC  = 24;
  localparam int TINY_NUM   = 110;
  localparam int TINY_SHIFT = 16;
  localparam int TINY_ROUND = 32768;
  localparam int RES_SHIFT  = 16;
  localparam int RES_ROUND  = 32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN = 2'd0,
    CFG_CELLS_X = 2'd1,
    CFG_CELLS_Y = 2'd2
  } cfg_index_e;

  localparam logic [1:0] PAT_QUADRANT = 2'd0;
  localparam logic [1:0] PAT_STRIP    = 2'd1;
  localparam logic [1:0] PAT_ONE      = 2'd2;

  typedef enum logic [2:0] {
    COND_ONE,
    COND_TWO,
    COND_TEN,
    COND_HUNDRED,
    COND_THOUSAND,
    COND_TINY
  } cond_e;

  typedef struct packed {
    logic [PT_W-1:0]         point_x;
    logic [PT_W-1:0]         point_y;
    logic signed [VAL_W-1:0] value_centre;
    logic signed [VAL_W-1:0] value_west;
    logic signed [VAL_W-1:0] value_east;
    logic signed [VAL_W-1:0] value_south;
    logic signed [VAL_W-1:0] value_north;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_W-1:0] applied_value;
    logic signed [RES_W-1:0] weight_centre;
    logic signed [RES_W-1:0] weight_west;
    logic signed [RES_W-1:0] weight_east;
    logic signed [RES_W-1:0] weight_south;
    logic signed [RES_W-1:0] weight_north;
  } out_word_t;

  // Integer conductivity; the tiny strip value is handled apart.
  function automatic logic [FACTOR_W-1:0] cond_factor(cond_e c);
    logic [FACTOR_W-1:0] f;
    unique case (c)
      COND_ONE:      f = FACTOR_W'(1);
      COND_TWO:      f = FACTOR_W'(2);
      COND_TEN:      f = FACTOR_W'(10);
      COND_HUNDRED:  f = FACTOR_W'(100);
      COND_THOUSAND: f = FACTOR_W'(1000);
      COND_TINY:     f = FACTOR_W'(TINY_NUM);
      default:       f = FACTOR_W'(1);
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

[src/jcs_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module jcs_cfg #(
  parameter int MAX_GRID = 1024,
  localparam int N_W = $clog2(MAX_GRID + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [jcs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [jcs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic [1:0]                      pattern_o,
  output logic [N_W-1:0]                  nx_o,
  output logic [N_W-1:0]                  ny_o,
  output logic [2*N_W-1:0]                nx2_o,
  output logic [2*N_W-1:0]                ny2_o
);
  import jcs_pkg::*;

  localparam int CLW       = (N_W > CFG_DATA_W) ? N_W : CFG_DATA_W;
  localparam int RST_CELLS = (MAX_GRID < 128) ? MAX_GRID : 128;
  localparam int RST_SQ    = RST_CELLS * RST_CELLS;

  logic [1:0]       pattern_q;
  logic [N_W-1:0]   nx_q, ny_q;
  logic [2*N_W-1:0] nx2_q, ny2_q;
  logic [CLW-1:0]   data_ext;
  logic [N_W-1:0]   cells_d;
  logic [2*N_W-1:0] cells_sq;

  assign cfg_ready_o = 1'b1;

  // Clamp the cell count and square it once at write time.
  always_comb begin
    data_ext = CLW'(cfg_data_i);
    if (data_ext > CLW'(MAX_GRID)) begin
      cells_d = N_W'(MAX_GRID);
    end else begin
      cells_d = N_W'(data_ext);
    end
    cells_sq = (2*N_W)'(cells_d) * (2*N_W)'(cells_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= PAT_ONE;
      nx_q      <= N_W'(RST_CELLS);
      ny_q      <= N_W'(RST_CELLS);
      nx2_q     <= (2*N_W)'(RST_SQ);
      ny2_q     <= (2*N_W)'(RST_SQ);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_PATTERN: pattern_q <= cfg_data_i[1:0];
        CFG_CELLS_X: begin
          nx_q  <= cells_d;
          nx2_q <= cells_sq;
        end
        CFG_CELLS_Y: begin
          ny_q  <= cells_d;
          ny2_q <= cells_sq;
        end
        default: ;
      endcase
    end
  end

  assign pattern_o = pattern_q;
  assign nx_o      = nx_q;
  assign ny_o      = ny_q;
  assign nx2_o     = nx2_q;
  assign ny2_o     = ny2_q;

endmodule

`default_nettype wire

[src/jcs_coef.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module jcs_coef #(
  parameter int MAX_GRID = 1024,
  localparam int N_W   = $clog2(MAX_GRID + 1),
  localparam int MAG_W = 2*N_W + jcs_pkg::FACTOR_W + jcs_pkg::COEF_FRAC,
  localparam int MC_W  = MAG_W + 2
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  jcs_pkg::in_word_t                             in_data_i,
  input  logic [1:0]                                    pattern_i,
  input  logic [N_W-1:0]                                nx_i,
  input  logic [N_W-1:0]                                ny_i,
  input  logic [2*N_W-1:0]                              nx2_i,
  input  logic [2*N_W-1:0]                              ny2_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic [jcs_pkg::NUM_TAPS-1:0][MC_W-1:0]        wt_o,
  output logic [jcs_pkg::NUM_TAPS-1:0][jcs_pkg::VAL_W:0] sval_o
);
  import jcs_pkg::*;

  localparam int CW = (N_W + 5 > 19) ? N_W + 5 : 19;
  localparam int PW = 2*N_W + FACTOR_W;

  function automatic cond_e cond_at(logic [1:0] pat, logic signed [CW-1:0] x,
                                    logic signed [CW-1:0] y, logic signed [CW-1:0] nx,
                                    logic signed [CW-1:0] ny);
    logic  xlow;
    logic  ylow;
    cond_e c;
    xlow = (x < nx);
    ylow = (y < ny);
    case (pat)
      PAT_QUADRANT: begin
        if (xlow) begin
          c = ylow ? COND_ONE : COND_TEN;
        end else begin
          c = ylow ? COND_THOUSAND : COND_HUNDRED;
        end
      end
      PAT_STRIP: begin
        if (((x <<< 5) < (nx * CW'(5))) || ((x <<< 6) > (nx * CW'(11)))) begin
          c = COND_TWO;
        end else begin
          c = COND_TINY;
        end
      end
      default: c = COND_ONE;
    endcase
    return c;
  endfunction

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  cond_e                            cond1_q [NUM_NB];
  cond_e                            cond1_d [NUM_NB];
  logic [NUM_TAPS-1:0][VAL_W-1:0]   val1_q, val2_q;
  logic [NUM_NB-1:0][MAG_W-1:0]     mag2_q, mag2_d;
  logic [NUM_TAPS-1:0][MC_W-1:0]    wt3_q, wt3_d;
  logic [NUM_TAPS-1:0][VAL_W:0]     sval3_q, sval3_d;

  logic signed [CW-1:0] xc, yc, nxs, nys;
  logic [2*N_W-1:0]     sq;
  logic [FACTOR_W-1:0]  fac;
  logic [PW-1:0]        prod;
  logic [PW:0]          rnd;
  logic [VAL_W:0]       vext;

  assign adv3       = !v3_q || out_ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  // Stage 1: region of each half-cell midpoint.
  always_comb begin
    xc  = $signed(CW'({in_data_i.point_x, 1'b0}));
    yc  = $signed(CW'({in_data_i.point_y, 1'b0}));
    nxs = $signed(CW'(nx_i));
    nys = $signed(CW'(ny_i));
    cond1_d[NB_W] = cond_at(pattern_i, xc - CW'(1), yc, nxs, nys);
    cond1_d[NB_E] = cond_at(pattern_i, xc + CW'(1), yc, nxs, nys);
    cond1_d[NB_S] = cond_at(pattern_i, xc, yc - CW'(1), nxs, nys);
    cond1_d[NB_N] = cond_at(pattern_i, xc, yc + CW'(1), nxs, nys);
  end

  // Stage 2: weight magnitudes in Q.24; the tiny value rounds half up.
  always_comb begin
    for (int k = 0; k < NUM_NB; k++) begin
      sq   = (k == NB_W || k == NB_E) ? nx2_i : ny2_i;
      fac  = cond_factor(cond1_q[k]);
      prod = PW'(sq) * PW'(fac);
      rnd  = {1'b0, prod} + (PW+1)'(TINY_ROUND);
      if (cond1_q[k] == COND_TINY) begin
        mag2_d[k] = MAG_W'(rnd >> TINY_SHIFT);
      end else begin
        mag2_d[k] = MAG_W'(prod) << COEF_FRAC;
      end
    end
  end

  // Stage 3: centre weight and signed tap values (neighbors negated).
  always_comb begin
    wt3_d[TAP_C] = MC_W'(mag2_q[NB_W]) + MC_W'(mag2_q[NB_E])
                 + MC_W'(mag2_q[NB_S]) + MC_W'(mag2_q[NB_N]);
    for (int k = 0; k < NUM_NB; k++) begin
      wt3_d[k+1] = MC_W'(mag2_q[k]);
    end
    for (int t = 0; t < NUM_TAPS; t++) begin
      vext = {val2_q[t][VAL_W-1], val2_q[t]};
      sval3_d[t] = (t == TAP_C) ? vext : -vext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      cond1_q <= cond1_d;
      val1_q  <= {in_data_i.value_north, in_data_i.value_south, in_data_i.value_east,
                  in_data_i.value_west, in_data_i.value_centre};
    end
    if (adv2) begin
      mag2_q <= mag2_d;
      val2_q <= val1_q;
    end
    if (adv3) begin
      wt3_q   <= wt3_d;
      sval3_q <= sval3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign wt_o        = wt3_q;
  assign sval_o      = sval3_q;

  `JCS_ASSERT_NEXT(a_stage1_hold, v1_q && !adv1, v1_q && $stable(val1_q), "stage 1 word lost under stall")
  `JCS_ASSERT(a_flat_weights, v3_q && (pattern_i == PAT_ONE), (wt3_q[1] == wt3_q[2]) && (wt3_q[3] == wt3_q[4]), "constant pattern gave unequal weights")

endmodule

`default_nettype wire

[src/jcs_apply.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module jcs_apply #(
  parameter int MAX_GRID = 1024,
  localparam int N_W   = $clog2(MAX_GRID + 1),
  localparam int MAG_W = 2*N_W + jcs_pkg::FACTOR_W + jcs_pkg::COEF_FRAC,
  localparam int MC_W  = MAG_W + 2
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           in_valid_i,
  output logic                                           in_ready_o,
  input  logic [jcs_pkg::NUM_TAPS-1:0][MC_W-1:0]         wt_i,
  input  logic [jcs_pkg::NUM_TAPS-1:0][jcs_pkg::VAL_W:0] sval_i,
  output logic                                           out_valid_o,
  input  logic                                           out_ready_i,
  output jcs_pkg::out_word_t                             out_data_o
);
  import jcs_pkg::*;

  localparam int NST   = 5;
  localparam int PL_W  = 2 * (VAL_W + 1);
  localparam int PH_W  = MC_W + 2;
  localparam int ACC_W = MC_W + 36;
  localparam int EXT_W = (ACC_W > RES_W + RES_SHIFT + 1) ? ACC_W : RES_W + RES_SHIFT + 1;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] adv;

  logic [NUM_TAPS-1:0][MC_W-1:0] wt4_q, wt5_q, wt6_q, wt7_q;
  logic signed [PL_W-1:0]  plo_q  [NUM_TAPS];
  logic signed [PL_W-1:0]  plo_d  [NUM_TAPS];
  logic signed [PH_W-1:0]  phi_q  [NUM_TAPS];
  logic signed [PH_W-1:0]  phi_d  [NUM_TAPS];
  logic signed [ACC_W-1:0] term_q [NUM_TAPS];
  logic signed [ACC_W-1:0] term_d [NUM_TAPS];
  logic signed [ACC_W-1:0] sa_q, sb_q, sc_q, sum_q;
  logic signed [EXT_W-1:0] sh;
  logic [EXT_W-RES_W:0]    upper;
  logic [RES_W-1:0]        res;
  out_word_t               out_q, out_d;

  always_comb begin
    adv[NST-1] = !vld_q[NST-1] || out_ready_i;
    for (int s = NST-2; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end
  assign in_ready_o = adv[0];

  // Stage 4: split each weight at bit 32 so no multiplier exceeds 33 x 33.
  always_comb begin
    for (int t = 0; t < NUM_TAPS; t++) begin
      plo_d[t] = $signed({1'b0, wt_i[t][31:0]}) * $signed(sval_i[t]);
      phi_d[t] = $signed({1'b0, wt_i[t][MC_W-1:32]}) * $signed(sval_i[t]);
    end
  end

  // Stage 5: recombine halves into full Q.40 products.
  always_comb begin
    for (int t = 0; t < NUM_TAPS; t++) begin
      term_d[t] = ($signed(ACC_W'(phi_q[t])) <<< 32) + $signed(ACC_W'(plo_q[t]));
    end
  end

  // Stage 8: round half up to Q.24 and saturate to 64 bits.
  always_comb begin
    sh    = $signed(EXT_W'(sum_q)) >>> RES_SHIFT;
    upper = sh[EXT_W-1:RES_W-1];
    if ((&upper) || !(|upper)) begin
      res = sh[RES_W-1:0];
    end else if (sh[EXT_W-1]) begin
      res = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(RES_W-1){1'b1}}};
    end
    out_d.applied_value = res;
    out_d.weight_centre = RES_W'(wt7_q[0]);
    out_d.weight_west   = -(RES_W'(wt7_q[1]));
    out_d.weight_east   = -(RES_W'(wt7_q[2]));
    out_d.weight_south  = -(RES_W'(wt7_q[3]));
    out_d.weight_north  = -(RES_W'(wt7_q[4]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s < NST; s++) begin
        if (adv[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      wt4_q <= wt_i;
    end
    if (adv[1]) begin
      term_q <= term_d;
      wt5_q  <= wt4_q;
    end
    if (adv[2]) begin
      sa_q  <= term_q[0] + term_q[1];
      sb_q  <= term_q[2] + term_q[3];
      sc_q  <= term_q[4] + $signed(ACC_W'(RES_ROUND));
      wt6_q <= wt5_q;
    end
    if (adv[3]) begin
      sum_q <= sa_q + sb_q + sc_q;
      wt7_q <= wt6_q;
    end
    if (adv[4]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[NST-1];
  assign out_data_o  = out_q;

  `JCS_ASSERT(a_weights_balance, out_valid_o, (out_data_o.weight_centre + out_data_o.weight_west + out_data_o.weight_east + out_data_o.weight_south + out_data_o.weight_north) == RES_W'(0), "stencil weights do not sum to zero")
  `JCS_ASSERT_NEXT(a_stage5_hold, vld_q[1] && !adv[1], vld_q[1] && $stable(term_q[0]), "product stage word lost under stall")

endmodule

`default_nettype wire

[src/jumping_coefficient_stencil.sv]
`timescale 1ns / 1ps
`default_nettype none

// Five-point diffusion stencil with region-wise conductivity. Takes one
// word per cycle while not stalled (grid point plus five Q16.16 values) and
// returns the five Q.24 weights and the saturated stencil sum. Eight register
// stages, sustaining one word per cycle while the output is not stalled;
// stage depth is set by the ten partial-product multipliers, none wider than
// 33 x 33, and the wide accumulate that follows them. Stalls on the output
// back up stage by stage, and empty stages keep taking words. The
// configuration port is always ready and a write takes effect on the next
// cycle; write it only while no word is in flight.
module jumping_coefficient_stencil #(
  parameter int MAX_GRID = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  jcs_pkg::in_word_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output jcs_pkg::out_word_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [jcs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [jcs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import jcs_pkg::*;

  localparam int N_W   = $clog2(MAX_GRID + 1);
  localparam int MAG_W = 2*N_W + FACTOR_W + COEF_FRAC;
  localparam int MC_W  = MAG_W + 2;

  logic [1:0]       pattern;
  logic [N_W-1:0]   nx, ny;
  logic [2*N_W-1:0] nx2, ny2;

  logic                          mid_valid, mid_ready;
  logic [NUM_TAPS-1:0][MC_W-1:0] mid_wt;
  logic [NUM_TAPS-1:0][VAL_W:0]  mid_sval;

  jcs_cfg #(
    .MAX_GRID(MAX_GRID)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pattern_o   (pattern),
    .nx_o        (nx),
    .ny_o        (ny),
    .nx2_o       (nx2),
    .ny2_o       (ny2)
  );

  jcs_coef #(
    .MAX_GRID(MAX_GRID)
  ) u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .pattern_i   (pattern),
    .nx_i        (nx),
    .ny_i        (ny),
    .nx2_i       (nx2),
    .ny2_i       (ny2),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .wt_o        (mid_wt),
    .sval_o      (mid_sval)
  );

  jcs_apply #(
    .MAX_GRID(MAX_GRID)
  ) u_apply (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .wt_i        (mid_wt),
    .sval_i      (mid_sval),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import jcs_pkg::*;

  localparam int GRID_MAX       = 1024;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 16;

  // Register index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // Pattern code that falls through to the constant conductivity.
  localparam logic [1:0] PAT_SPARE = 2'd3;

  localparam logic [31:0] V_TOP    = 32'h7FFF_FFFF;
  localparam logic [31:0] V_BOTTOM = 32'h8000_0000;

  localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] SAT_LO = ~SAT_HI;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_word_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Shadow copy of the block's registers.
  logic [1:0] cur_pattern = PAT_ONE;
  int         cur_nx      = 128;
  int         cur_ny      = 128;

  out_word_t  queued_stencils[$];
  out_word_t  head_stencil;
  int         fail_count     = 0;
  int         idle_cycles    = 0;
  int         feed_gap_pct   = 26;
  int         sink_stall_pct = 81;

  jumping_coefficient_stencil #(
    .MAX_GRID(GRID_MAX)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stencil predictor
  // ---------------------------------------------------------------------------

  // Conductivity class at midpoint (xn / 2nx, yn / 2ny).
  function automatic cond_e region_cond(int xn, int yn);
    cond_e c;
    case (cur_pattern)
      PAT_QUADRANT: begin
        if (xn < cur_nx) begin
          if (yn < cur_ny) c = COND_ONE;
          else c = COND_TEN;
        end else begin
          if (yn < cur_ny) c = COND_THOUSAND;
          else c = COND_HUNDRED;
        end
      end
      PAT_STRIP: begin
        if (32 * xn < 5 * cur_nx || 64 * xn > 11 * cur_nx) c = COND_TWO;
        else c = COND_TINY;
      end
      default: c = COND_ONE;
    endcase
    return c;
  endfunction

  // Coupling magnitude n*n*a in Q.24.
  function automatic logic [63:0] coupling_mag(int n, cond_e c);
    logic [63:0] sq;
    logic [63:0] f;
    sq = 64'(n) * 64'(n);
    case (c)
      COND_TWO:      f = 64'd2;
      COND_TEN:      f = 64'd10;
      COND_HUNDRED:  f = 64'd100;
      COND_THOUSAND: f = 64'd1000;
      default:       f = 64'd1;
    endcase
    // Strip value is 110 / 2^40: round to nearest, ties up.
    if (c == COND_TINY) return (sq * 64'd110 + 64'd32768) >> 16;
    return (sq * f) << 24;
  endfunction

  function automatic logic signed [127:0] widen(logic [31:0] v);
    return {{96{v[31]}}, v};
  endfunction

  function automatic out_word_t stencil_of(in_word_t w);
    int px;
    int py;
    logic [63:0] mw, me, ms, mn, mc;
    logic signed [127:0] acc;
    logic signed [127:0] sum;
    out_word_t r;
    px = w.point_x;
    py = w.point_y;
    mw = coupling_mag(cur_nx, region_cond(2 * px - 1, 2 * py));
    me = coupling_mag(cur_nx, region_cond(2 * px + 1, 2 * py));
    ms = coupling_mag(cur_ny, region_cond(2 * px, 2 * py - 1));
    mn = coupling_mag(cur_ny, region_cond(2 * px, 2 * py + 1));
    mc = mw + me + ms + mn;
    acc = $signed({64'd0, mc}) * widen(w.value_centre)
        - $signed({64'd0, mw}) * widen(w.value_west)
        - $signed({64'd0, me}) * widen(w.value_east)
        - $signed({64'd0, ms}) * widen(w.value_south)
        - $signed({64'd0, mn}) * widen(w.value_north);
    // Q.40 down to Q.24, ties toward +inf.
    sum = (acc + 128'sd32768) >>> 16;
    if (sum > SAT_HI) r.applied_value = SAT_HI[63:0];
    else if (sum < SAT_LO) r.applied_value = SAT_LO[63:0];
    else r.applied_value = sum[63:0];
    r.weight_centre = mc;
    r.weight_west   = -mw;
    r.weight_east   = -me;
    r.weight_south  = -ms;
    r.weight_north  = -mn;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking, output stalls, watchdog
  // ---------------------------------------------------------------------------

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, field, $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (queued_stencils.size() == 0) begin
        $display("%0t ns: result word with none expected, applied_value %0d",
                 $time, out_data_o.applied_value);
        fail_count++;
      end else begin
        head_stencil = queued_stencils.pop_front();
        check_field("applied_value", head_stencil.applied_value, out_data_o.applied_value);
        check_field("weight_centre", head_stencil.weight_centre, out_data_o.weight_centre);
        check_field("weight_west", head_stencil.weight_west, out_data_o.weight_west);
        check_field("weight_east", head_stencil.weight_east, out_data_o.weight_east);
        check_field("weight_south", head_stencil.weight_south, out_data_o.weight_south);
        check_field("weight_north", head_stencil.weight_north, out_data_o.weight_north);
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: entered and left at a falling edge
  // ---------------------------------------------------------------------------

  task automatic push_point(input logic [9:0] px, input logic [9:0] py,
                            input logic [31:0] vc, input logic [31:0] vw,
                            input logic [31:0] ve, input logic [31:0] vs,
                            input logic [31:0] vn);
    in_word_t w;
    w.point_x      = px;
    w.point_y      = py;
    w.value_centre = vc;
    w.value_west   = vw;
    w.value_east   = ve;
    w.value_south  = vs;
    w.value_north  = vn;
    while ($urandom_range(0, 99) < feed_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    queued_stencils.push_back(stencil_of(w));
    // Hold valid; the next call or a flush decides what comes next.
    @(negedge clk_i);
  endtask

  task automatic flush_points();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (queued_stencils.size() != 0);
  endtask

  task automatic load_grid(input logic [1:0] pattern, input int cells_x,
                           input int cells_y, input bit poke_spare = 1'b0);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    int count;
    flush_points();
    idx[0] = CFG_PATTERN; val[0] = CFG_DATA_W'(pattern);
    idx[1] = CFG_CELLS_X; val[1] = cells_x[CFG_DATA_W-1:0];
    idx[2] = CFG_CELLS_Y; val[2] = cells_y[CFG_DATA_W-1:0];
    idx[3] = CFG_SPARE;   val[3] = '1;
    count = poke_spare ? 4 : 3;
    for (int k = 0; k < count; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[k])
        CFG_PATTERN: cur_pattern = val[k][1:0];
        CFG_CELLS_X: cur_nx = (val[k] > GRID_MAX) ? GRID_MAX : val[k];
        CFG_CELLS_Y: cur_ny = (val[k] > GRID_MAX) ? GRID_MAX : val[k];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Random pickers
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: v = V_TOP;
          1: v = V_BOTTOM;
          2: v = '0;
          default: v = '1;
        endcase
      end
      1, 2: v = $urandom_range(0, 131071) - 65536;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Mostly interior points, some anywhere, some right at a region edge.
  function automatic logic [9:0] pick_coord(int n, bit along_x);
    int c;
    case ($urandom_range(0, 9))
      0, 1: c = $urandom_range(0, 1023);
      2, 3: begin
        if (cur_pattern == PAT_STRIP && along_x)
          c = (n * (10 + $urandom_range(0, 1))) / 128 + $urandom_range(0, 2) - 1;
        else
          c = n / 2 + $urandom_range(0, 2) - 1;
      end
      default: c = (n >= 2) ? $urandom_range(1, n - 1) : $urandom_range(1, 1023);
    endcase
    return c[9:0];
  endfunction

  function automatic int pick_cells();
    int n;
    case ($urandom_range(0, 5))
      0: n = 2;
      1: n = 3;
      2: n = GRID_MAX;
      3: n = $urandom_range(0, 2047);
      default: n = $urandom_range(2, 64);
    endcase
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_values();
    push_point(10'd1, 10'd1, V_TOP, V_BOTTOM, 32'd0, 32'hFFFF_FFFF, 32'd1);
    push_point(10'd127, 10'd127, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
               32'h1234_5678, 32'h8765_4321);
    push_point(10'd1023, 10'd0, V_BOTTOM, V_TOP, V_TOP, V_TOP, V_TOP);
  endtask

  task automatic test_quadrant_jumps();
    load_grid(PAT_QUADRANT, 16, 16);
    push_point(10'd7, 10'd7, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000,
               32'd5, 32'd0);
    push_point(10'd8, 10'd8, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5);
    push_point(10'd8, 10'd7, V_TOP, 32'd0, V_BOTTOM, 32'd0, V_TOP);
    push_point(10'd7, 10'd8, 32'hFFFF_FFFF, V_TOP, 32'd1, V_BOTTOM, 32'h0000_FFFF);
    push_point(10'd15, 10'd15, 32'h0100_0000, 32'h00FF_0000, 32'h0101_0000,
               32'hFF00_0000, 32'h0000_0001);
    // Largest grid in the thousand region: drive the sum into saturation.
    load_grid(PAT_QUADRANT, GRID_MAX, GRID_MAX);
    push_point(10'd700, 10'd100, V_TOP, V_BOTTOM, V_BOTTOM, V_BOTTOM, V_BOTTOM);
    push_point(10'd700, 10'd100, V_BOTTOM, V_TOP, V_TOP, V_TOP, V_TOP);
    push_point(10'd512, 10'd512, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_thin_strip();
    load_grid(PAT_STRIP, 128, 128);
    push_point(10'd9, 10'd5, 32'h0001_0000, 32'd3, 32'hFFFF_FFFD, 32'd0, V_TOP);
    push_point(10'd10, 10'd5, V_TOP, V_BOTTOM, V_TOP, V_BOTTOM, V_TOP);
    push_point(10'd11, 10'd5, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
    push_point(10'd12, 10'd5, 32'hFFFF_8000, 32'h0000_8000, 32'd7, 32'd9, 32'd11);
    // Rounding of the tiny coefficient, with a y cell count that is not a power of two.
    load_grid(PAT_STRIP, GRID_MAX, 1000);
    push_point(10'd84, 10'd500, 32'h0000_8000, 32'hFFFF_7FFF, 32'd1,
               32'hFFFF_FFFF, 32'd32768);
    push_point(10'd80, 10'd1, V_BOTTOM, V_BOTTOM, V_BOTTOM, V_BOTTOM, V_BOTTOM);
  endtask

  task automatic test_grid_extremes();
    // Zero cells zero the x weights; the spare index must change nothing.
    load_grid(PAT_ONE, 0, 1, 1'b1);
    push_point(10'd0, 10'd0, V_TOP, 32'd1, 32'd2, 32'd3, 32'd4);
    push_point(10'd1023, 10'd1023, V_BOTTOM, V_TOP, V_BOTTOM, V_TOP, V_BOTTOM);
    // Oversized cell counts clamp to the maximum.
    load_grid(PAT_SPARE, 2047, GRID_MAX);
    push_point(10'd1023, 10'd1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
               32'h0001_0000, 32'h0001_0000);
    load_grid(PAT_QUADRANT, 2, 2047);
    push_point(10'd1, 10'd1, 32'd100, 32'hFFFF_FF9C, 32'd50, 32'hFFFF_FFCE, 32'd0);
    push_point(10'd0, 10'd1023, V_TOP, V_TOP, V_BOTTOM, V_BOTTOM, 32'd0);
    load_grid(PAT_STRIP, 1, 0);
    push_point(10'd0, 10'd0, 32'h0ABC_DEF0, 32'hF543_2110, V_TOP, 32'd0, V_BOTTOM);
  endtask

  task automatic test_random_sweep();
    int gaps[3]   = '{26, 81, 0};
    int stalls[3] = '{81, 26, 0};
    for (int p = 0; p < 3; p++) begin
      feed_gap_pct   = gaps[p];
      sink_stall_pct = stalls[p];
      for (int seg = 0; seg < 4; seg++) begin
        if (p == 0 && seg == 0) load_grid(PAT_QUADRANT, 2, GRID_MAX);
        else if (p == 0 && seg == 1) load_grid(PAT_STRIP, GRID_MAX, 2);
        else load_grid(2'($urandom_range(0, 3)), pick_cells(), pick_cells());
        for (int k = 0; k < 63; k++) begin
          // Let the pipeline run dry once per setting.
          if (k == 31) flush_points();
          push_point(pick_coord(cur_nx, 1'b1), pick_coord(cur_ny, 1'b0),
                     pick_value(), pick_value(), pick_value(), pick_value(),
                     pick_value());
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_values();
    test_quadrant_jumps();
    test_thin_strip();
    test_grid_extremes();
    test_random_sweep();
    flush_points();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && queued_stencils.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
